>>> src/kufef_pkg.sv
`timescale 1ns / 1ps

package kufef_pkg;

    // Fixed field widths of node numbers, the node count and ranks.
    localparam int NODE_W = 8;
    localparam int CNT_W  = 9;
    localparam int RANK_W = 4;

    // Ranks saturate here.
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // Reset value of the node count register.
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 9'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND,
        S_COMP_RD,
        S_COMP,
        S_JOIN,
        S_RANK,
        S_DONE
    } t_state;

endpackage

>>> src/kufef_forest.sv
`timescale 1ns / 1ps

module kufef_forest #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [AW-1:0]                o_rd_link,
    output logic [kufef_pkg::RANK_W-1:0] o_rd_rank,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [AW-1:0]                i_wr_link,
    input  logic [kufef_pkg::RANK_W-1:0] i_wr_rank
);
    import kufef_pkg::*;

    // Each word holds the parent link above the rank.
    logic [AW+RANK_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [AW+RANK_W-1:0] r_rd_word;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_link, i_wr_rank};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_addr];
            r_rd_vld  <= r_valid[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // A node never written since the last clear is a singleton of rank zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_link = r_rd_vld ? r_rd_word[AW+RANK_W-1:RANK_W] : r_rd_addr;
    assign o_rd_rank = r_rd_vld ? r_rd_word[RANK_W-1:0] : '0;

endmodule

>>> src/kruskal_union_find_edge_filter_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents                            Handshake
// edge      in         i_node_a, i_node_b, i_start_graph        i_in_valid / o_in_ready
// result    out        o_tree_edge, o_root_kept, o_range_error  o_out_valid / i_out_ready
// config    in         i_cfg_node_count                         i_cfg_we (no wait)
//
// An edge is worked on from acceptance until its result is loaded: a parent walk
// from each endpoint to its root, a rewrite of each link that path compression
// changes, the join, and a rank update when the join bumps a rank. An edge that is
// out of range goes straight to the result. Every hop and every rewrite is its own
// read or write of the single forest memory.
// Reset is synchronous and active low; it makes every node a singleton at once
// and sets the node count to 256. A stalled result waits in the output register
// and holds back only the next edge's result, not the acceptance of that edge.
module kruskal_union_find_edge_filter_core #(
    parameter int MAX_NODES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kufef_pkg::CNT_W-1:0]  i_cfg_node_count,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [kufef_pkg::NODE_W-1:0] i_node_a,
    input  logic [kufef_pkg::NODE_W-1:0] i_node_b,
    input  logic                        i_start_graph,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_tree_edge,
    output logic [kufef_pkg::NODE_W-1:0] o_root_kept,
    output logic                        o_range_error
);
    import kufef_pkg::*;

    // Node numbers are 8 bits wide, so no more than 256 entries are ever used.
    localparam int DEPTH = (MAX_NODES < 256) ? MAX_NODES : 256;
    localparam int AW    = $clog2(DEPTH);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_node_count;

    logic [AW-1:0]       r_node_a;
    logic [AW-1:0]       r_node_b;
    logic [AW-1:0]       r_cur;
    logic                r_side;
    logic [AW-1:0]       r_root_a;
    logic [AW-1:0]       r_root_b;
    logic [RANK_W-1:0]   r_rank_a;
    logic [RANK_W-1:0]   r_rank_b;
    logic                r_tree;
    logic [NODE_W-1:0]   r_keep;
    logic                r_err;

    logic                r_out_valid;
    logic                r_out_tree;
    logic [NODE_W-1:0]   r_out_root;
    logic                r_out_err;

    logic                w_accept;
    logic                w_in_ok;
    logic                w_out_load;
    logic [AW-1:0]       w_side_root;
    logic                w_swap;
    logic [AW-1:0]       w_hi;
    logic [AW-1:0]       w_lo;
    logic [RANK_W-1:0]   w_hi_rank;
    logic [RANK_W-1:0]   w_lo_rank;
    logic                w_same;
    logic                w_bump;

    logic                w_clear;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_rd_link;
    logic [RANK_W-1:0]   w_rd_rank;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [AW-1:0]       w_wr_link;
    logic [RANK_W-1:0]   w_wr_rank;

    kufef_forest #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_forest (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_link (w_rd_link),
        .o_rd_rank (w_rd_rank),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_link (w_wr_link),
        .i_wr_rank (w_wr_rank)
    );

    assign w_accept = i_in_valid && o_in_ready;

    // Both endpoints must lie below the node count and below the forest size.
    assign w_in_ok = (CNT_W'(i_node_a) < r_node_count) &&
                     (CNT_W'(i_node_b) < r_node_count) &&
                     (17'(i_node_a) < 17'(MAX_NODES)) &&
                     (17'(i_node_b) < 17'(MAX_NODES));

    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_side_root = r_side ? r_root_b : r_root_a;

    // Union by rank: the root of lower rank hangs below the other one.
    assign w_swap    = r_rank_a < r_rank_b;
    assign w_hi      = w_swap ? r_root_b : r_root_a;
    assign w_lo      = w_swap ? r_root_a : r_root_b;
    assign w_hi_rank = w_swap ? r_rank_b : r_rank_a;
    assign w_lo_rank = w_swap ? r_rank_a : r_rank_b;
    assign w_same    = r_root_a == r_root_b;
    assign w_bump    = !w_same && (r_rank_a == r_rank_b) && (r_rank_a < RANK_MAX);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_ok ? S_FIND_RD : S_DONE;
                end
            end
            S_FIND_RD: n_state = S_FIND;
            S_FIND: begin
                if (w_rd_link == r_cur) begin
                    n_state = S_COMP_RD;
                end
            end
            S_COMP_RD: begin
                if (r_cur == w_side_root) begin
                    n_state = r_side ? S_JOIN : S_FIND_RD;
                end else begin
                    n_state = S_COMP;
                end
            end
            S_COMP: n_state = S_COMP_RD;
            S_JOIN: n_state = w_bump ? S_RANK : S_DONE;
            S_RANK: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port and handshake controls. Reads and writes never share a
    // cycle, so no forwarding is needed between them.
    always_comb begin
        o_in_ready = 1'b0;
        w_clear    = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_cur;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_cur;
        w_wr_link  = w_side_root;
        w_wr_rank  = w_rd_rank;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_clear    = w_accept && i_start_graph;
            end
            S_FIND_RD: w_rd_en = 1'b1;
            S_FIND: begin
                // Chase the next parent straight away while not at the root.
                w_rd_en   = w_rd_link != r_cur;
                w_rd_addr = w_rd_link;
            end
            S_COMP_RD: w_rd_en = r_cur != w_side_root;
            S_COMP:    w_wr_en = 1'b1;
            S_JOIN: begin
                w_wr_en   = !w_same;
                w_wr_addr = w_lo;
                w_wr_link = w_hi;
                w_wr_rank = w_lo_rank;
            end
            S_RANK: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_hi;
                w_wr_link = w_hi;
                w_wr_rank = w_hi_rank + 1'b1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_node_count;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the edge in flight.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_node_a <= AW'(i_node_a);
                    r_node_b <= AW'(i_node_b);
                    r_cur    <= AW'(i_node_a);
                    r_side   <= 1'b0;
                    r_tree   <= 1'b0;
                    r_keep   <= '0;
                    r_err    <= !w_in_ok;
                end
            end
            S_FIND: begin
                if (w_rd_link == r_cur) begin
                    // Root found; go back to the endpoint for compression.
                    if (r_side) begin
                        r_root_b <= r_cur;
                        r_rank_b <= w_rd_rank;
                        r_cur    <= r_node_b;
                    end else begin
                        r_root_a <= r_cur;
                        r_rank_a <= w_rd_rank;
                        r_cur    <= r_node_a;
                    end
                end else begin
                    r_cur <= w_rd_link;
                end
            end
            S_COMP_RD: begin
                if (r_cur == w_side_root && !r_side) begin
                    r_side <= 1'b1;
                    r_cur  <= r_node_b;
                end
            end
            S_COMP: r_cur <= w_rd_link;
            S_JOIN: begin
                r_tree <= !w_same;
                r_keep <= NODE_W'(w_hi);
            end
            S_FIND_RD, S_RANK, S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_tree <= r_tree;
            r_out_root <= r_keep;
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tree_edge   = r_out_tree;
    assign o_root_kept   = r_out_root;
    assign o_range_error = r_out_err;

    // The sequencer never reads and writes the forest in one cycle.
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rd_en && w_wr_en))
        else $error("forest read and write in the same cycle");

    // The forest is only modified while an edge is being worked on.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_wr_en)
        else $error("forest written while idle");

    // A rejected edge goes straight to the result without searching the forest.
    a_reject_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_in_ok) |=> (r_state == S_DONE))
        else $error("out-of-range edge entered the search");

    // A range error never comes with a tree edge.
    a_err_not_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_range_error && o_tree_edge))
        else $error("range error reported as tree edge");

endmodule
